// ===== rtl/pem_pkg.sv =====
// Shared types, constants and helpers for the Prewitt edge magnitude block.
// Used by the top level and by its checker; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pem_pkg;

    // Default frame limits, handed to the top level as parameter defaults.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Configuration port.
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;

    // Datapath widths.
    localparam int CH_W   = 8;             // one color channel
    localparam int PIX_W  = 10;            // r + g + b
    localparam int SUM_W  = 12;            // sum of three intensities
    localparam int GRAD_W = SUM_W + 1;     // signed gradient
    localparam int SQ_W   = 2 * SUM_W;     // one squared gradient
    localparam int ROOT_W = 12;            // integer square root
    localparam int RAD_W  = 2 * ROOT_W;    // square root radicand
    localparam int REM_W  = ROOT_W + 3;    // square root partial remainder
    localparam int MAG_W  = 8;

    // Divide by three and saturate: roots from SAT_ROOT up give the maximum,
    // smaller roots use a reciprocal multiply that is exact below 2^16.
    localparam int SAT_ROOT     = 768;
    localparam int MAG_MAX      = 255;
    localparam int DIV_IN_W     = 10;
    localparam int RECIP_W      = 16;
    localparam int RECIP3       = 43691;
    localparam int RECIP3_SHIFT = 17;

    // Flags that travel with a result down the pipeline.
    typedef struct packed {
        logic eor;
        logic eof;
    } t_tag;

    // Clamp a frame dimension register to 1..mx.
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned mx);
        int unsigned u;
        u = 32'(v);
        if (u == 0) begin
            u = 1;
        end else if (u > mx) begin
            u = mx;
        end
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pem_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module pem_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/prewitt_edge_magnitude.sv =====
// Prewitt 3x3 edge magnitude on a raster RGB pixel stream; uses pem_pkg and pem_ram.
// Each beat carries one pixel (mode 0) or a flush tick (mode 1, value zero); the
// intensity sum r+g+b goes through a line RAM holding the two previous rows and a
// 3x3 window, and the result floor(sqrt(gx^2+gy^2)/3), saturated to 255, comes out
// with the beat W+1 positions later, so W+1 flush beats drain a frame. The block
// takes one beat per clock: the line RAM is read at the column of the entering beat
// and written from stage 1, with write-to-read forwarding for one-pixel rows.
// A result passes the window, gradient and square registers, a 12-stage square
// root and a divide by three. The input stalls only while a result waits in the
// output register and the output is stalled. Writing either dimension register
// restarts the frame; the block must be idle then. The RAM needs no clearing pass:
// the row position decides whether a read is used.
`timescale 1ns / 1ps
`default_nettype none

module prewitt_edge_magnitude
    import pem_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_mode,
    input  wire logic [CH_W-1:0]      i_red,
    input  wire logic [CH_W-1:0]      i_green,
    input  wire logic [CH_W-1:0]      i_blue,
    // output channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [MAG_W-1:0]          o_magnitude,
    output logic                      o_end_of_row,
    output logic                      o_end_of_frame
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int LINE_W = 2 * PIX_W;

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    logic w_en;
    logic w_accept;

    logic             r_out_valid;
    logic [MAG_W-1:0] r_magnitude;
    t_tag             r_out_tag;

    // The whole pipeline moves unless a result is held at a stalled output.
    assign w_en       = !(r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && w_en;
    assign o_in_stall = !w_en;

    // ------------------------------------------------------------------
    // Frame position and configuration
    // ------------------------------------------------------------------
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic             w_first;
    logic             w_pix_ok;
    logic [PIX_W-1:0] w_pix;
    logic             w_emit;
    logic             w_eof;
    logic [COL_W:0]   w_col_inc;
    logic             w_row_end;

    // Classify the entering beat by its position in the frame.
    always_comb begin
        w_first   = (r_col == '0);
        w_pix_ok  = (i_mode == 1'b0) && (r_row < ROW_W'(r_height));
        w_pix     = w_pix_ok ? (PIX_W'(i_red) + PIX_W'(i_green) + PIX_W'(i_blue))
                             : '0;
        w_emit    = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && !w_first);
        w_eof     = w_first && (r_row == ROW_W'(r_height) + ROW_W'(1));
        w_col_inc = {1'b0, r_col} + (COL_W+1)'(1);
        w_row_end = (w_col_inc >= (COL_W+1)'(r_width));
    end

    // Next position; the last result of a frame starts the next one.
    always_comb begin
        n_col = COL_W'(w_col_inc);
        n_row = r_row;
        if (w_emit && w_eof) begin
            n_col = '0;
            n_row = '0;
        end else if (w_row_end) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end
    end

    // Dimension registers hold clamped values; a write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(clamp_dim(CFG_W'(RST_WIDTH), MAX_WIDTH));
            r_height <= HGT_W'(clamp_dim(CFG_W'(RST_HEIGHT), MAX_HEIGHT));
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    r_width <= WID_W'(clamp_dim(i_cfg_data, MAX_WIDTH));
                end
                REG_IMAGE_HEIGHT: begin
                    r_height <= HGT_W'(clamp_dim(i_cfg_data, MAX_HEIGHT));
                end
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line RAM read data arrives, window update and write-back
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_first;
    logic             r_s1_top_ok;
    logic             r_s1_mid_ok;
    logic             r_s1_emit;
    t_tag             r_s1_tag;
    logic [PIX_W-1:0] r_s1_pix;

    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;
    logic [LINE_W-1:0] w_ram_q;
    logic [LINE_W-1:0] w_line_q;
    logic [PIX_W-1:0]  w_top;
    logic [PIX_W-1:0]  w_mid;
    logic              w_s1_go;

    assign w_s1_go = w_en && r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                // The beat leaving stage 1 writes the same column this cycle.
                r_fwd <= r_s1_valid && (r_s1_col == r_col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_col    <= r_col;
            r_s1_first  <= w_first;
            r_s1_top_ok <= (r_row >= ROW_W'(2));
            r_s1_mid_ok <= (r_row >= ROW_W'(1));
            r_s1_emit   <= w_emit;
            r_s1_tag    <= '{eor: w_first, eof: w_eof};
            r_s1_pix    <= w_pix;
            r_fwd_data  <= {w_mid, r_s1_pix};
        end
    end

    // Each entry holds {row above, middle row} for its column.
    pem_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (w_s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({w_mid, r_s1_pix}),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_ram_q)
    );

    // Rows not yet seen in this frame read as zero.
    always_comb begin
        w_line_q = r_fwd ? r_fwd_data : w_ram_q;
        w_top    = r_s1_top_ok ? w_line_q[LINE_W-1:PIX_W] : '0;
        w_mid    = r_s1_mid_ok ? w_line_q[PIX_W-1:0] : '0;
    end

    // Window columns a (left) and b (center); the new column is the right one.
    logic [PIX_W-1:0] r_win_a [0:2];
    logic [PIX_W-1:0] r_win_b [0:2];
    logic [PIX_W-1:0] w_rc    [0:2];

    // The first column of a row closes the previous row against zero padding.
    always_comb begin
        w_rc[0] = r_s1_first ? '0 : w_top;
        w_rc[1] = r_s1_first ? '0 : w_mid;
        w_rc[2] = r_s1_first ? '0 : r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int k = 0; k < 3; k++) begin
                r_win_a[k] <= '0;
                r_win_b[k] <= '0;
            end
        end else if (w_s1_go) begin
            r_win_a[0] <= r_s1_first ? '0 : r_win_b[0];
            r_win_a[1] <= r_s1_first ? '0 : r_win_b[1];
            r_win_a[2] <= r_s1_first ? '0 : r_win_b[2];
            r_win_b[0] <= r_s1_tag.eof ? '0 : w_top;
            r_win_b[1] <= r_s1_tag.eof ? '0 : w_mid;
            r_win_b[2] <= r_s1_tag.eof ? '0 : r_s1_pix;
        end
    end

    // Kernel sums: rows for the vertical gradient, columns for the horizontal.
    logic [SUM_W-1:0]         w_sum_top, w_sum_bot, w_sum_lft, w_sum_rgt;
    logic signed [GRAD_W-1:0] w_gx, w_gy;

    always_comb begin
        w_sum_top = SUM_W'(r_win_a[0]) + SUM_W'(r_win_b[0]) + SUM_W'(w_rc[0]);
        w_sum_bot = SUM_W'(r_win_a[2]) + SUM_W'(r_win_b[2]) + SUM_W'(w_rc[2]);
        w_sum_lft = SUM_W'(r_win_a[0]) + SUM_W'(r_win_a[1]) + SUM_W'(r_win_a[2]);
        w_sum_rgt = SUM_W'(w_rc[0]) + SUM_W'(w_rc[1]) + SUM_W'(w_rc[2]);
        w_gx      = $signed({1'b0, w_sum_bot}) - $signed({1'b0, w_sum_top});
        w_gy      = $signed({1'b0, w_sum_lft}) - $signed({1'b0, w_sum_rgt});
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3: gradients, then their squares
    // ------------------------------------------------------------------
    logic                     r_s2_valid;
    t_tag                     r_s2_tag;
    logic signed [GRAD_W-1:0] r_s2_gx, r_s2_gy;
    logic                     r_s3_valid;
    t_tag                     r_s3_tag;
    logic [SQ_W-1:0]          r_s3_sqx, r_s3_sqy;

    logic [SUM_W-1:0] w_ax, w_ay;
    logic [SQ_W-1:0]  w_sqx, w_sqy;

    always_comb begin
        w_ax  = r_s2_gx[GRAD_W-1] ? SUM_W'(-r_s2_gx) : SUM_W'(r_s2_gx);
        w_ay  = r_s2_gy[GRAD_W-1] ? SUM_W'(-r_s2_gy) : SUM_W'(r_s2_gy);
        w_sqx = w_ax * w_ax;
        w_sqy = w_ay * w_ay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_tag <= r_s1_tag;
            r_s2_gx  <= w_gx;
            r_s2_gy  <= w_gy;
            r_s3_tag <= r_s2_tag;
            r_s3_sqx <= w_sqx;
            r_s3_sqy <= w_sqy;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, restoring digit recurrence
    // ------------------------------------------------------------------
    logic [SQ_W:0]      w_rad_full;
    logic [ROOT_W:0]    r_rt_valid;
    t_tag               r_rt_tag  [0:ROOT_W];
    logic [RAD_W-1:0]   r_rt_rad  [0:ROOT_W];
    logic [REM_W-1:0]   r_rt_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]  r_rt_root [0:ROOT_W];
    logic [RAD_W-1:0]   n_rt_rad  [0:ROOT_W];
    logic [REM_W-1:0]   n_rt_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]  n_rt_root [0:ROOT_W];
    logic [REM_W-1:0]   w_rt_sh   [0:ROOT_W-1];
    logic [REM_W-1:0]   w_rt_try  [0:ROOT_W-1];
    logic [ROOT_W-1:0]  w_rt_ge;

    // Both gradients stay below 2296, so the sum of squares fits RAD_W bits.
    assign w_rad_full = r_s3_sqx + r_s3_sqy;

    always_comb begin
        n_rt_rad[0]  = w_rad_full[RAD_W-1:0];
        n_rt_rem[0]  = '0;
        n_rt_root[0] = '0;
        for (int k = 0; k < ROOT_W; k++) begin
            w_rt_sh[k]  = {r_rt_rem[k][REM_W-3:0], r_rt_rad[k][RAD_W-1 -: 2]};
            w_rt_try[k] = REM_W'({r_rt_root[k], 2'b01});
            w_rt_ge[k]  = (w_rt_sh[k] >= w_rt_try[k]);
            n_rt_rem[k+1]  = w_rt_ge[k] ? (w_rt_sh[k] - w_rt_try[k]) : w_rt_sh[k];
            n_rt_root[k+1] = {r_rt_root[k][ROOT_W-2:0], w_rt_ge[k]};
            n_rt_rad[k+1]  = {r_rt_rad[k][RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_valid <= '0;
        end else if (w_en) begin
            r_rt_valid <= {r_rt_valid[ROOT_W-1:0], r_s3_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rt_tag[0] <= r_s3_tag;
            for (int k = 0; k < ROOT_W; k++) begin
                r_rt_tag[k+1] <= r_rt_tag[k];
            end
            for (int k = 0; k <= ROOT_W; k++) begin
                r_rt_rad[k]  <= n_rt_rad[k];
                r_rt_rem[k]  <= n_rt_rem[k];
                r_rt_root[k] <= n_rt_root[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divide by three with saturation, output register
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0]           w_root;
    logic                        w_sat;
    logic [DIV_IN_W+RECIP_W-1:0] w_prod;
    logic [MAG_W-1:0]            w_mag;

    always_comb begin
        w_root = r_rt_root[ROOT_W];
        w_sat  = (w_root >= ROOT_W'(SAT_ROOT));
        w_prod = w_root[DIV_IN_W-1:0] * RECIP_W'(RECIP3);
        w_mag  = w_sat ? MAG_W'(MAG_MAX) : w_prod[RECIP3_SHIFT +: MAG_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_rt_valid[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_rt_valid[ROOT_W]) begin
            r_magnitude <= w_mag;
            r_out_tag   <= r_rt_tag[ROOT_W];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_magnitude    = r_magnitude;
    assign o_end_of_row   = r_out_tag.eor;
    assign o_end_of_frame = r_out_tag.eof;

endmodule

`default_nettype wire

// ===== rtl/pem_checker.sv =====
// Port-level checks for the Prewitt edge magnitude block, bound to its top level.
// Uses pem_pkg for the result width.
`timescale 1ns / 1ps
`default_nettype none

module pem_checker
    import pem_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_stall,
    input wire logic             i_out_valid,
    input wire logic             i_out_stall,
    input wire logic [MAG_W-1:0] i_magnitude,
    input wire logic             i_end_of_row,
    input wire logic             i_end_of_frame
);

    // A stalled result beat stays and does not change.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_magnitude)
            && $stable(i_end_of_row) && $stable(i_end_of_frame))
        else $error("stalled result beat changed or vanished");

    // The last result of a frame is also the last of its row.
    a_eof_eor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_end_of_frame |-> i_end_of_row)
        else $error("end of frame without end of row");

    // The input only stalls behind a held result at a stalled output.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // Reset leaves no result pending.
    a_reset_clear : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind prewitt_edge_magnitude pem_checker u_pem_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_stall     (o_in_stall),
    .i_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .i_magnitude    (o_magnitude),
    .i_end_of_row   (o_end_of_row),
    .i_end_of_frame (o_end_of_frame)
);

`default_nettype wire

// ===== sim/tb_prewitt_edge_magnitude.sv =====
// Self-checking testbench for prewitt_edge_magnitude: a directed table, then random frames.
// Depends on pem_pkg and the RTL top level; expected magnitudes come from a predictor here.
`timescale 1ns / 1ps

module tb_prewitt_edge_magnitude;
    import pem_pkg::*;

    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int DRAIN_CYCLES = 40;     // well past the pipeline
    localparam int HOLD_CYCLES  = 300;    // one long output hold-off
    localparam int HOLD_AFTER   = 120;    // results seen before that hold-off starts
    localparam int ITEM_GOAL    = 1500;   // input beats in all, before the last frames finish
    localparam int CALM_FROM    = 1300;   // no idling on either side in this beat range
    localparam int CALM_TO      = 1500;
    localparam int MAX_REPORTS  = 10;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             eor;
        logic             eof;
    } t_mag_beat;

    typedef enum logic {ROW_DIMS, ROW_BEAT} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [CFG_W-1:0] dim_w;
        logic [CFG_W-1:0] dim_h;
        logic             mode;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             typed;
        t_mag_beat        want;
    } t_dir_row;

    // Block ports, all known from time zero.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 mode      = MODE_PIXEL;
    logic [CH_W-1:0]      red       = '0;
    logic [CH_W-1:0]      green     = '0;
    logic [CH_W-1:0]      blue      = '0;
    logic                 out_stall = 1'b0;
    wire                  in_stall;
    wire                  out_valid;
    wire  [MAG_W-1:0]     magnitude;
    wire                  end_of_row;
    wire                  end_of_frame;

    prewitt_edge_magnitude u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_mode         (mode),
        .i_red          (red),
        .i_green        (green),
        .i_blue         (blue),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_magnitude    (magnitude),
        .o_end_of_row   (end_of_row),
        .o_end_of_frame (end_of_frame)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state: dimension registers, two line stores, the 3x3 window
    // (indexed [column][row], column 2 newest, row 2 current) and frame position.
    logic [CFG_W-1:0]           width_reg  = CFG_W'(RST_WIDTH);
    logic [CFG_W-1:0]           height_reg = CFG_W'(RST_HEIGHT);
    logic [PIX_W-1:0]           line_prev2 [MAX_W];
    logic [PIX_W-1:0]           line_prev1 [MAX_W];
    logic [2:0][2:0][PIX_W-1:0] win3       = '0;
    int unsigned                cur_col    = 0;
    int unsigned                cur_row    = 0;
    int unsigned                frame_outs = 0;

    t_mag_beat   mag_expect_q [$];
    t_dir_row    dir_tab [$];
    int unsigned beats_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned err_cnt      = 0;
    t_mag_beat   seen_beat;
    t_mag_beat   want_beat;

    function automatic bit calm_now();
        return beats_sent >= CALM_FROM && beats_sent < CALM_TO;
    endfunction

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned mx);
        if (v == 0) begin
            return 1;
        end
        if (v > mx) begin
            return mx;
        end
        return v;
    endfunction

    function automatic int unsigned floor_sqrt(input int unsigned x);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int i = 15; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Vertical gradient is bottom row minus top row, horizontal is left minus right.
    function automatic logic [MAG_W-1:0] prewitt_mag(input logic [2:0][PIX_W-1:0] lc,
                                                     input logic [2:0][PIX_W-1:0] cc,
                                                     input logic [2:0][PIX_W-1:0] rc);
        int          gx;
        int          gy;
        int unsigned q;
        gx = (int'(lc[2]) + int'(cc[2]) + int'(rc[2])) - (int'(lc[0]) + int'(cc[0]) + int'(rc[0]));
        gy = (int'(lc[0]) + int'(lc[1]) + int'(lc[2])) - (int'(rc[0]) + int'(rc[1]) + int'(rc[2]));
        q = floor_sqrt(gx * gx + gy * gy) / 3;
        return (q > MAG_MAX) ? MAG_W'(MAG_MAX) : MAG_W'(q);
    endfunction

    task automatic restart_frame();
        cur_col    = 0;
        cur_row    = 0;
        frame_outs = 0;
        win3       = '0;
    endtask

    // Advance the predictor by one accepted input beat.
    task automatic prewitt_predict(input logic m, input logic [CH_W-1:0] r, g, b,
                                   output bit has, output t_mag_beat res);
        int unsigned w;
        int unsigned frame;
        int unsigned c;
        int unsigned rw;
        int unsigned idx;
        int unsigned v;
        int unsigned top;
        int unsigned mid;
        logic [MAG_W-1:0] mag;
        w     = eff_dim(width_reg, MAX_W);
        frame = w * eff_dim(height_reg, MAX_H);
        if (cur_col >= w) begin
            cur_col = 0;
        end
        c   = cur_col;
        rw  = cur_row;
        idx = rw * w + c;
        has = (idx >= w + 1);
        v   = 0;
        mag = '0;
        res = '0;
        // Flush beats and anything past the frame feed zero.
        if (m == MODE_PIXEL && idx < frame) begin
            v = int'(r) + int'(g) + int'(b);
        end
        // The last column of a row is finished by the window before it shifts.
        if (has && c == 0) begin
            mag = prewitt_mag(win3[1], win3[2], '0);
        end
        top = (rw >= 2) ? int'(line_prev2[c]) : 0;
        mid = (rw >= 1) ? int'(line_prev1[c]) : 0;
        if (c == 0) begin
            win3[0] = '0;
            win3[1] = '0;
        end else begin
            win3[0] = win3[1];
            win3[1] = win3[2];
        end
        win3[2]       = {PIX_W'(v), PIX_W'(mid), PIX_W'(top)};
        line_prev2[c] = PIX_W'(mid);
        line_prev1[c] = PIX_W'(v);
        if (has && c != 0) begin
            mag = prewitt_mag(win3[0], win3[1], win3[2]);
        end
        cur_col = c + 1;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = (rw + 1) & 32'h7FF;
        end
        if (has) begin
            res.mag = mag;
            res.eor = (c == 0);
            res.eof = (frame_outs + 1 >= frame);
            if (res.eof) begin
                restart_frame();
            end else begin
                frame_outs = (frame_outs + 1) & 32'hFFFFF;
            end
        end
    endtask

    // Dimension writes happen only once the block has drained.
    task automatic write_dims(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
        in_valid <= 1'b0;
        while (mag_expect_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= wv;
        @(negedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= hv;
        @(negedge clk);
        cfg_we     <= 1'b0;
        width_reg  = wv;
        height_reg = hv;
        restart_frame();
    endtask

    // Offer one input beat after a random gap and hold it until it is taken.
    task automatic send_beat(input logic m, input logic [CH_W-1:0] r, g, b,
                             input logic typed, input t_mag_beat want);
        bit        has;
        t_mag_beat pred;
        while (!calm_now() && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        beats_sent++;
        prewitt_predict(m, r, g, b, has, pred);
        if (typed) begin
            mag_expect_q.push_back(want);
        end else if (has) begin
            mag_expect_q.push_back(pred);
        end
        @(negedge clk);
    endtask

    // One frame of textured pixels with a few flushes, then mixed padding beats.
    // A nonzero limit cuts the frame short.
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned limit);
        int unsigned     total;
        int unsigned     spread;
        int unsigned     base;
        logic            m;
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
        total = w * h + w + 1;
        if (limit != 0 && limit < total) begin
            total = limit;
        end
        case ($urandom_range(0, 4))
            0: begin
                spread = 0;
            end
            1: begin
                spread = 3;
            end
            2: begin
                spread = 15;
            end
            3: begin
                spread = 63;
            end
            default: begin
                spread = 255;
            end
        endcase
        base = $urandom_range(0, 255);
        for (int unsigned k = 0; k < total; k++) begin
            if (k < w * h) begin
                m = ($urandom_range(0, 9) == 0) ? MODE_FLUSH : MODE_PIXEL;
                r = CH_W'(base + $urandom_range(0, spread));
                g = CH_W'(base + $urandom_range(0, spread));
                b = CH_W'(base + $urandom_range(0, spread));
            end else begin
                m = ($urandom_range(0, 3) == 0) ? MODE_PIXEL : MODE_FLUSH;
                r = CH_W'($urandom);
                g = CH_W'($urandom);
                b = CH_W'($urandom);
            end
            send_beat(m, r, g, b, 1'b0, '0);
        end
    endtask

    function automatic t_dir_row dims_row(input int unsigned w, input int unsigned h);
        t_dir_row row;
        row       = '0;
        row.kind  = ROW_DIMS;
        row.dim_w = CFG_W'(w);
        row.dim_h = CFG_W'(h);
        return row;
    endfunction

    function automatic t_dir_row beat_row(input logic m, input int unsigned r, g, b);
        t_dir_row row;
        row       = '0;
        row.kind  = ROW_BEAT;
        row.mode  = m;
        row.red   = CH_W'(r);
        row.green = CH_W'(g);
        row.blue  = CH_W'(b);
        return row;
    endfunction

    function automatic t_dir_row check_row(input logic m, input int unsigned r, g, b,
                                           input int unsigned mag, input logic eor, eof);
        t_dir_row row;
        row          = beat_row(m, r, g, b);
        row.typed    = 1'b1;
        row.want.mag = MAG_W'(mag);
        row.want.eor = eor;
        row.want.eof = eof;
        return row;
    endfunction

    task automatic report_error(input string what, input t_mag_beat want, input t_mag_beat got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("%0t ns: %s: expected mag %0d eor %0b eof %0b, got mag %0d eor %0b eof %0b",
                     $time, what, want.mag, want.eor, want.eof, got.mag, got.eor, got.eof);
        end
    endtask

    // Output side: random stall, plus one long hold-off while input keeps coming.
    initial begin : out_side
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AFTER && in_valid) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm_now() && $urandom_range(0, 99) < 20;
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            seen_beat.mag = magnitude;
            seen_beat.eor = end_of_row;
            seen_beat.eof = end_of_frame;
            if (mag_expect_q.size() == 0) begin
                report_error("unexpected result", '0, seen_beat);
            end else begin
                want_beat = mag_expect_q.pop_front();
                if (want_beat.mag !== seen_beat.mag || want_beat.eor !== seen_beat.eor ||
                    want_beat.eof !== seen_beat.eof) begin
                    report_error("mismatch", want_beat, seen_beat);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned wv;
        int unsigned hv;
        int unsigned nfr;
        int unsigned w;
        int unsigned h;

        restart_frame();

        // 2x2 frame of full white: every output saturates.
        dir_tab.push_back(dims_row(2, 2));
        repeat (3) dir_tab.push_back(beat_row(MODE_PIXEL, 255, 255, 255));
        dir_tab.push_back(check_row(MODE_PIXEL, 255, 255, 255, 255, 1'b0, 1'b0));
        dir_tab.push_back(check_row(MODE_FLUSH, 0, 0, 0, 255, 1'b1, 1'b0));
        dir_tab.push_back(check_row(MODE_FLUSH, 0, 0, 0, 255, 1'b0, 1'b0));
        dir_tab.push_back(check_row(MODE_FLUSH, 0, 0, 0, 255, 1'b1, 1'b1));
        // Flushes inside the frame act as black; colored beats past the frame are ignored.
        repeat (3) dir_tab.push_back(beat_row(MODE_FLUSH, 0, 0, 0));
        dir_tab.push_back(check_row(MODE_FLUSH, 0, 0, 0, 0, 1'b0, 1'b0));
        dir_tab.push_back(check_row(MODE_PIXEL, 255, 255, 255, 0, 1'b1, 1'b0));
        dir_tab.push_back(check_row(MODE_PIXEL, 255, 0, 255, 0, 1'b0, 1'b0));
        dir_tab.push_back(check_row(MODE_PIXEL, 0, 255, 0, 0, 1'b1, 1'b1));
        // Zero dimensions act as one pixel.
        dir_tab.push_back(dims_row(0, 0));
        dir_tab.push_back(beat_row(MODE_PIXEL, 255, 255, 255));
        dir_tab.push_back(beat_row(MODE_FLUSH, 0, 0, 0));
        dir_tab.push_back(beat_row(MODE_FLUSH, 0, 0, 0));
        // Single row with one channel per pixel.
        dir_tab.push_back(dims_row(3, 1));
        dir_tab.push_back(beat_row(MODE_PIXEL, 255, 0, 0));
        dir_tab.push_back(beat_row(MODE_PIXEL, 0, 255, 0));
        dir_tab.push_back(beat_row(MODE_PIXEL, 0, 0, 255));
        repeat (4) dir_tab.push_back(beat_row(MODE_FLUSH, 0, 0, 0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_DIMS) begin
                write_dims(dir_tab[i].dim_w, dir_tab[i].dim_h);
            end else begin
                send_beat(dir_tab[i].mode, dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue,
                          dir_tab[i].typed, dir_tab[i].want);
            end
        end

        // Oversized registers clamp to the maximum; feed one widest row and a few results.
        write_dims(11'd2047, 11'd1024);
        send_frame(MAX_W, MAX_H, MAX_W + 11);
        write_dims(11'd1, 11'd2047);
        send_frame(1, MAX_H, 30);

        // Small frames, back to back, with the occasional cut frame and drain pause.
        while (beats_sent < ITEM_GOAL) begin
            case ($urandom_range(0, 9))
                0: begin
                    wv = 0;
                end
                1: begin
                    wv = 1;
                end
                default: begin
                    wv = $urandom_range(2, 12);
                end
            endcase
            case ($urandom_range(0, 9))
                0: begin
                    hv = 0;
                end
                1: begin
                    hv = 1;
                end
                default: begin
                    hv = $urandom_range(2, 6);
                end
            endcase
            write_dims(CFG_W'(wv), CFG_W'(hv));
            w   = eff_dim(CFG_W'(wv), MAX_W);
            h   = eff_dim(CFG_W'(hv), MAX_H);
            nfr = $urandom_range(1, 3);
            for (int unsigned f = 0; f < nfr; f++) begin
                if ($urandom_range(0, 7) == 0 && mag_expect_q.size() != 0) begin
                    in_valid <= 1'b0;
                    while (mag_expect_q.size() != 0) begin
                        @(negedge clk);
                    end
                end
                if (f == nfr - 1 && $urandom_range(0, 4) == 0) begin
                    send_frame(w, h, $urandom_range(1, w * h + w));
                end else begin
                    send_frame(w, h, 0);
                end
            end
        end

        in_valid <= 1'b0;
        while (mag_expect_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_cnt == 0 && mag_expect_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
